FILE: rtl/psue_pkg.sv
// Shared constants, types and helpers of the particle swarm update engine.
`default_nettype none
package psue_pkg;

	localparam int NUM_PARTICLES = 16;
	localparam int NUM_DIMS      = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int EMIT_N        = (NUM_DIMS < MAX_RESULTS) ? NUM_DIMS : MAX_RESULTS;

	// fixed field widths
	localparam int P_W   = 4;
	localparam int D_W   = 3;
	localparam int CFG_W = 3;

	// derived storage widths
	localparam int PIDX_W = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
	localparam int DIM_W  = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam int DEPTH  = NUM_PARTICLES * NUM_DIMS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic signed [31:0] COST_MAX = 32'sh7FFF_FFFF;

	// register indexes
	localparam logic [CFG_W-1:0] CFG_MOMENTUM   = 3'd0;
	localparam logic [CFG_W-1:0] CFG_OWN_GAIN   = 3'd1;
	localparam logic [CFG_W-1:0] CFG_SWARM_GAIN = 3'd2;
	localparam logic [CFG_W-1:0] CFG_SPEED_FRAC = 3'd3;
	localparam logic [CFG_W-1:0] CFG_USE_GLOBAL = 3'd4;

	// register reset values
	localparam logic [15:0] RST_MOMENTUM   = 16'd16384;
	localparam logic [15:0] RST_OWN_GAIN   = 16'd32768;
	localparam logic [15:0] RST_SWARM_GAIN = 16'd32768;
	localparam logic [15:0] RST_SPEED_FRAC = 16'd6554;

	// request codes
	typedef enum logic [1:0] {
		REQ_BOUNDS = 2'd0,
		REQ_COORD  = 2'd1,
		REQ_COST   = 2'd2,
		REQ_MOVE   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CRD,
		ST_CWR,
		ST_RD,
		ST_MUL,
		ST_SUM,
		ST_LIM,
		ST_WR
	} state_t;

	typedef struct packed {
		logic accept;
		logic cwr;
		logic mul;
		logic sum;
		logic lim;
		logic wr;
	} cmd_t;

	typedef struct packed {
		logic go_cost;
		logic go_move;
		logic dim_last;
		logic wr_ok;
	} status_t;

	// flat store address of one coordinate
	function automatic logic [ADDR_W-1:0] addr_of(input logic [PIDX_W-1:0] p,
		input logic [DIM_W-1:0] d);
		addr_of = ADDR_W'(int'(p) * NUM_DIMS + int'(d));
	endfunction

endpackage
`default_nettype wire

FILE: rtl/psue_ram.sv
// Generic one-write one-read RAM with registered read data.
`default_nettype none
module psue_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/psue_ctrl.sv
// Sequencer of the particle swarm update engine.
`default_nettype none
module psue_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire psue_pkg::status_t status,
	output psue_pkg::cmd_t         cmd
);

	psue_pkg::state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psue_pkg::ST_IDLE: begin
				if (in_valid && status.go_cost) state_d = psue_pkg::ST_CRD;
				else if (in_valid && status.go_move) state_d = psue_pkg::ST_RD;
			end
			psue_pkg::ST_CRD: state_d = psue_pkg::ST_CWR;
			psue_pkg::ST_CWR: begin
				state_d = status.dim_last ? psue_pkg::ST_IDLE : psue_pkg::ST_CRD;
			end
			psue_pkg::ST_RD:  state_d = psue_pkg::ST_MUL;
			psue_pkg::ST_MUL: state_d = psue_pkg::ST_SUM;
			psue_pkg::ST_SUM: state_d = psue_pkg::ST_LIM;
			psue_pkg::ST_LIM: state_d = psue_pkg::ST_WR;
			psue_pkg::ST_WR: begin
				if (status.wr_ok) begin
					state_d = status.dim_last ? psue_pkg::ST_IDLE : psue_pkg::ST_RD;
				end
			end
			default: state_d = psue_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			psue_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			psue_pkg::ST_CWR: cmd.cwr = 1'b1;
			psue_pkg::ST_MUL: cmd.mul = 1'b1;
			psue_pkg::ST_SUM: cmd.sum = 1'b1;
			psue_pkg::ST_LIM: cmd.lim = 1'b1;
			psue_pkg::ST_WR:  cmd.wr = status.wr_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psue_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/psue_dp.sv
// Datapath of the particle swarm update engine: stores, costs and update arithmetic.
`default_nettype none
module psue_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire psue_pkg::cmd_t              cmd,
	output psue_pkg::status_t                status,
	input  wire logic                        cfg_we,
	input  wire logic [psue_pkg::CFG_W-1:0]  cfg_index,
	input  wire logic [15:0]                 cfg_data,
	input  wire logic [1:0]                  req_type,
	input  wire logic [psue_pkg::P_W-1:0]    particle_index,
	input  wire logic [psue_pkg::D_W-1:0]    dim_index,
	input  wire logic signed [31:0]          value_a,
	input  wire logic signed [31:0]          value_b,
	input  wire logic signed [31:0]          cost_value,
	input  wire logic [15:0]                 rand_own,
	input  wire logic [15:0]                 rand_swarm,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [psue_pkg::P_W-1:0]         out_particle,
	output logic [psue_pkg::D_W-1:0]         out_dim,
	output logic signed [31:0]               out_position,
	output logic signed [31:0]               out_velocity,
	output logic                             last_dim
);

	localparam int NP = psue_pkg::NUM_PARTICLES;
	localparam int ND = psue_pkg::NUM_DIMS;
	localparam int PW = psue_pkg::PIDX_W;
	localparam int DW = psue_pkg::DIM_W;
	localparam int AW = psue_pkg::ADDR_W;

	// configuration
	logic [15:0] mom_q, own_q, swm_q, frac_q;
	logic        glob_q;

	// swarm state
	logic signed [31:0] lo_q [ND];
	logic signed [31:0] hi_q [ND];
	logic signed [31:0] sbest_q [ND];
	logic signed [31:0] rbest_q [ND];
	logic signed [31:0] pcost_q [NP];
	logic [NP-1:0]      pvalid_q;
	logic signed [31:0] scost_q, rcost_q;
	logic               rvalid_q, phase_q;
	logic [PW-1:0]      ridx_q;

	// per-request context
	logic [PW-1:0] p_q;
	logic [DW-1:0] dim_q;
	logic          upd_q, win_q, pbinv_q;
	logic [15:0]   k1_q, k2_q;

	// arithmetic registers
	logic signed [31:0] x_q;
	logic signed [48:0] pmv_q;
	logic signed [49:0] pown_q, pswm_q, plim_q;
	logic signed [37:0] vraw_q;
	logic signed [33:0] vmax_q;
	logic signed [31:0] v_q;

	// output register
	logic               oval_q;
	logic [psue_pkg::P_W-1:0] opart_q;
	logic [psue_pkg::D_W-1:0] odim_q;
	logic signed [31:0] opos_q, ovel_q;
	logic               olast_q;

	// decoded request
	logic [PW-1:0] in_p;
	logic [DW-1:0] in_d;
	logic          p_ok, d_ok, go_bounds, go_coord, go_cost, go_move;

	assign in_p = PW'(particle_index);
	assign in_d = DW'(dim_index);
	assign p_ok = int'(particle_index) < NP;
	assign d_ok = int'(dim_index) < ND;
	assign go_bounds = (req_type == psue_pkg::REQ_BOUNDS) && d_ok;
	assign go_coord  = (req_type == psue_pkg::REQ_COORD) && p_ok && d_ok;
	assign go_cost   = (req_type == psue_pkg::REQ_COST) && p_ok;
	assign go_move   = (req_type == psue_pkg::REQ_MOVE) && p_ok;

	// emission of the current dimension
	logic emit, emit_last;
	assign emit      = {1'b0, dim_q} < (DW+1)'(psue_pkg::EMIT_N);
	assign emit_last = {1'b0, dim_q} == (DW+1)'(psue_pkg::EMIT_N - 1);

	assign status.go_cost  = go_cost;
	assign status.go_move  = go_move;
	assign status.dim_last = int'(dim_q) == ND - 1;
	assign status.wr_ok    = !emit || !oval_q || !out_stall;

	// coordinate stores
	logic [AW-1:0]      cur_addr, in_addr;
	logic signed [31:0] pos_rd, vel_rd, pb_rd, nx;
	logic               pos_we, pb_we;

	assign cur_addr = psue_pkg::addr_of(p_q, dim_q);
	assign in_addr  = psue_pkg::addr_of(in_p, in_d);
	assign pos_we   = (cmd.accept && go_coord) || cmd.wr;
	assign pb_we    = (cmd.cwr && upd_q) || (cmd.wr && pbinv_q);

	psue_ram #(.WIDTH(32), .DEPTH(psue_pkg::DEPTH)) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (cmd.wr ? cur_addr : in_addr),
		.wdata (cmd.wr ? nx : value_a),
		.raddr (cur_addr),
		.rdata (pos_rd)
	);

	psue_ram #(.WIDTH(32), .DEPTH(psue_pkg::DEPTH)) u_vel (
		.clk   (clk),
		.we    (pos_we),
		.waddr (cmd.wr ? cur_addr : in_addr),
		.wdata (cmd.wr ? v_q : value_b),
		.raddr (cur_addr),
		.rdata (vel_rd)
	);

	psue_ram #(.WIDTH(32), .DEPTH(psue_pkg::DEPTH)) u_pbest (
		.clk   (clk),
		.we    (pb_we),
		.waddr (cur_addr),
		.wdata (cmd.wr ? x_q : pos_rd),
		.raddr (cur_addr),
		.rdata (pb_rd)
	);

	// operand differences of one dimension
	logic signed [31:0] pb_eff, best;
	logic signed [32:0] d_own, d_swm, range;
	assign pb_eff = pbinv_q ? pos_rd : pb_rd;
	assign best   = glob_q ? sbest_q[dim_q] : rbest_q[dim_q];
	assign d_own  = {pb_eff[31], pb_eff} - {pos_rd[31], pos_rd};
	assign d_swm  = {best[31], best} - {pos_rd[31], pos_rd};
	assign range  = {hi_q[dim_q][31], hi_q[dim_q]} - {lo_q[dim_q][31], lo_q[dim_q]};

	// sum with half-up rounding
	logic signed [51:0] ssum;
	assign ssum = 52'(pmv_q) + 52'(pown_q) + 52'(pswm_q) + 52'sd8192;

	// velocity limit and saturation
	logic signed [39:0] vw, vmaxw, v1, v2;
	logic signed [31:0] vsat;
	always_comb begin
		vw    = 40'(vraw_q);
		vmaxw = 40'(vmax_q);
		v1 = (vw > vmaxw) ? vmaxw : vw;
		v2 = (v1 < -vmaxw) ? -vmaxw : v1;
		if (v2 > 40'sh0_7FFF_FFFF) vsat = 32'sh7FFF_FFFF;
		else if (v2 < -40'sh0_8000_0000) vsat = 32'sh8000_0000;
		else vsat = v2[31:0];
	end

	// new position clamped to the bounds
	logic signed [32:0] nxw, hiw, low;
	logic signed [32:0] nx1, nx2;
	always_comb begin
		nxw = {x_q[31], x_q} + {v_q[31], v_q};
		hiw = {hi_q[dim_q][31], hi_q[dim_q]};
		low = {lo_q[dim_q][31], lo_q[dim_q]};
		nx1 = (nxw > hiw) ? hiw : nxw;
		nx2 = (nx1 < low) ? low : nx1;
		nx  = nx2[31:0];
	end

	// arithmetic pipeline of one dimension
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			x_q    <= pos_rd;
			pmv_q  <= $signed({1'b0, mom_q}) * vel_rd;
			pown_q <= $signed({1'b0, k1_q}) * d_own;
			pswm_q <= $signed({1'b0, k2_q}) * d_swm;
			plim_q <= $signed({1'b0, frac_q}) * range;
		end
		if (cmd.sum) begin
			vraw_q <= 38'(ssum >>> 14);
			vmax_q <= 34'(plim_q >>> 16);
		end
		if (cmd.lim) begin
			v_q <= vsat;
		end
	end

	// bounds, best snapshots and request context
	always_ff @(posedge clk) begin
		if (cmd.accept && go_bounds) begin
			lo_q[in_d] <= value_a;
			hi_q[in_d] <= value_b;
		end
		if (cmd.cwr && win_q) begin
			rbest_q[dim_q] <= pos_rd;
		end
		if (cmd.accept && go_move && !phase_q && rvalid_q && (rcost_q < scost_q)) begin
			for (int i = 0; i < ND; i++) sbest_q[i] <= rbest_q[i];
		end
		if (cmd.accept) begin
			p_q  <= in_p;
			k1_q <= 16'(({16'd0, own_q} * {16'd0, rand_own}) >> 16);
			k2_q <= 16'(({16'd0, swm_q} * {16'd0, rand_swarm}) >> 16);
		end
	end

	// cost tracking and control flags
	logic               r_open, r_win, p_upd;
	always_comb begin
		r_open = !rvalid_q || phase_q;
		p_upd  = cost_value < pcost_q[in_p];
		r_win  = r_open || (cost_value < rcost_q)
			|| ((cost_value == rcost_q) && (in_p <= ridx_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NP; i++) pcost_q[i] <= psue_pkg::COST_MAX;
			pvalid_q <= '0;
			scost_q  <= psue_pkg::COST_MAX;
			rcost_q  <= psue_pkg::COST_MAX;
			rvalid_q <= 1'b0;
			ridx_q   <= '0;
			phase_q  <= 1'b0;
			dim_q    <= '0;
			upd_q    <= 1'b0;
			win_q    <= 1'b0;
			pbinv_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				dim_q <= '0;
			end else if (cmd.cwr || cmd.wr) begin
				dim_q <= DW'(int'(dim_q) + 1);
			end
			if (cmd.accept && go_cost) begin
				phase_q <= 1'b0;
				upd_q   <= p_upd;
				win_q   <= r_win;
				if (p_upd) begin
					pcost_q[in_p]  <= cost_value;
					pvalid_q[in_p] <= 1'b1;
				end
				if (r_win) begin
					rcost_q  <= cost_value;
					ridx_q   <= in_p;
					rvalid_q <= 1'b1;
				end else if (phase_q) begin
					rcost_q  <= psue_pkg::COST_MAX;
					rvalid_q <= 1'b0;
				end
			end
			if (cmd.accept && go_move) begin
				if (!phase_q && rvalid_q && (rcost_q < scost_q)) begin
					scost_q <= rcost_q;
				end
				phase_q        <= 1'b1;
				upd_q          <= 1'b0;
				win_q          <= 1'b0;
				pbinv_q        <= !pvalid_q[in_p];
				pvalid_q[in_p] <= 1'b1;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mom_q  <= psue_pkg::RST_MOMENTUM;
			own_q  <= psue_pkg::RST_OWN_GAIN;
			swm_q  <= psue_pkg::RST_SWARM_GAIN;
			frac_q <= psue_pkg::RST_SPEED_FRAC;
			glob_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psue_pkg::CFG_MOMENTUM:   mom_q  <= cfg_data;
				psue_pkg::CFG_OWN_GAIN:   own_q  <= cfg_data;
				psue_pkg::CFG_SWARM_GAIN: swm_q  <= cfg_data;
				psue_pkg::CFG_SPEED_FRAC: frac_q <= cfg_data;
				psue_pkg::CFG_USE_GLOBAL: glob_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (cmd.wr && emit) begin
			oval_q <= 1'b1;
		end else if (!out_stall) begin
			oval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && emit) begin
			opart_q <= psue_pkg::P_W'(p_q);
			odim_q  <= psue_pkg::D_W'(dim_q);
			opos_q  <= nx;
			ovel_q  <= v_q;
			olast_q <= emit_last;
		end
	end

	assign out_valid    = oval_q;
	assign out_particle = opart_q;
	assign out_dim      = odim_q;
	assign out_position = opos_q;
	assign out_velocity = ovel_q;
	assign last_dim     = olast_q;

endmodule
`default_nettype wire

FILE: rtl/particle_swarm_update_engine.sv
// Particle swarm update engine: top level joining sequencer and datapath.
// Load requests complete on accept; a cost report runs one store read and one copy
// step per dimension. A move runs read, multiply, sum, limit and write per dimension;
// the write step of an emitted dimension waits while the output holds a stalled result.
// Reset clears control state, costs, flags and configuration registers; coordinate stores are not cleared.
`default_nettype none
module particle_swarm_update_engine (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [psue_pkg::CFG_W-1:0] cfg_index,
	input  wire logic [15:0]                cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [1:0]                 req_type,
	input  wire logic [psue_pkg::P_W-1:0]   particle_index,
	input  wire logic [psue_pkg::D_W-1:0]   dim_index,
	input  wire logic signed [31:0]         value_a,
	input  wire logic signed [31:0]         value_b,
	input  wire logic signed [31:0]         cost_value,
	input  wire logic [15:0]                rand_own,
	input  wire logic [15:0]                rand_swarm,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [psue_pkg::P_W-1:0]        out_particle,
	output logic [psue_pkg::D_W-1:0]        out_dim,
	output logic signed [31:0]              out_position,
	output logic signed [31:0]              out_velocity,
	output logic                            last_dim
);

	psue_pkg::cmd_t    cmd;
	psue_pkg::status_t status;

	psue_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	psue_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_type       (req_type),
		.particle_index (particle_index),
		.dim_index      (dim_index),
		.value_a        (value_a),
		.value_b        (value_b),
		.cost_value     (cost_value),
		.rand_own       (rand_own),
		.rand_swarm     (rand_swarm),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_particle   (out_particle),
		.out_dim        (out_dim),
		.out_position   (out_position),
		.out_velocity   (out_velocity),
		.last_dim       (last_dim)
	);

endmodule
`default_nettype wire

FILE: sim/particle_swarm_update_engine_tb.sv
// Self-checking testbench of the particle swarm update engine.
`timescale 1ns / 1ps
`default_nettype none
module particle_swarm_update_engine_tb;

	typedef struct {
		psue_pkg::req_t               kind;
		logic [psue_pkg::P_W-1:0]     p;
		logic [psue_pkg::D_W-1:0]     d;
		logic signed [31:0]           a;
		logic signed [31:0]           b;
		logic signed [31:0]           cost;
		logic [15:0]                  r1;
		logic [15:0]                  r2;
	} swarm_req_t;

	typedef struct {
		logic [psue_pkg::P_W-1:0]     p;
		logic [psue_pkg::D_W-1:0]     d;
		logic signed [31:0]           pos;
		logic signed [31:0]           vel;
		logic                         last;
	} coord_update_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [psue_pkg::CFG_W-1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_stall;
	logic [1:0] req_type;
	logic [psue_pkg::P_W-1:0] particle_index;
	logic [psue_pkg::D_W-1:0] dim_index;
	logic signed [31:0] value_a, value_b, cost_value;
	logic [15:0] rand_own, rand_swarm;
	logic out_valid, out_stall;
	logic [psue_pkg::P_W-1:0] out_particle;
	logic [psue_pkg::D_W-1:0] out_dim;
	logic signed [31:0] out_position, out_velocity;
	logic last_dim;

	particle_swarm_update_engine u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .particle_index(particle_index), .dim_index(dim_index),
		.value_a(value_a), .value_b(value_b), .cost_value(cost_value),
		.rand_own(rand_own), .rand_swarm(rand_swarm),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_particle(out_particle), .out_dim(out_dim),
		.out_position(out_position), .out_velocity(out_velocity), .last_dim(last_dim)
	);

	// clock
	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	int errors;
	bit quiet;
	coord_update_t pending_updates[$];

	// swarm state mirror
	longint pos_m[psue_pkg::NUM_PARTICLES*psue_pkg::NUM_DIMS];
	longint vel_m[psue_pkg::NUM_PARTICLES*psue_pkg::NUM_DIMS];
	longint pbest_m[psue_pkg::NUM_PARTICLES*psue_pkg::NUM_DIMS];
	longint pbest_cost_m[psue_pkg::NUM_PARTICLES];
	bit     pbest_ok[psue_pkg::NUM_PARTICLES];
	longint low_m[psue_pkg::NUM_DIMS], high_m[psue_pkg::NUM_DIMS];
	longint swarm_pos_m[psue_pkg::NUM_DIMS], round_pos_m[psue_pkg::NUM_DIMS];
	longint swarm_cost_m, round_cost_m;
	bit     round_ok, moving;
	int     round_idx;
	longint gain_m, gain_own, gain_swarm, frac_m;
	bit     follow_global;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// compute expected coordinate updates of one accepted request
	task automatic apply_request(input swarm_req_t it);
		int base;
		longint k1, k2, x, lo, hi, s, v, vmax, nx, bst;
		coord_update_t u;
		base = int'(it.p) * psue_pkg::NUM_DIMS;
		case (it.kind)
			psue_pkg::REQ_BOUNDS: begin
				low_m[it.d] = it.a;
				high_m[it.d] = it.b;
			end
			psue_pkg::REQ_COORD: begin
				pos_m[base + it.d] = it.a;
				vel_m[base + it.d] = it.b;
			end
			psue_pkg::REQ_COST: begin
				if (moving) begin
					moving = 0;
					round_ok = 0;
					round_cost_m = psue_pkg::COST_MAX;
				end
				if (longint'(it.cost) < pbest_cost_m[it.p]) begin
					for (int i = 0; i < psue_pkg::NUM_DIMS; i++)
						pbest_m[base + i] = pos_m[base + i];
					pbest_cost_m[it.p] = it.cost;
					pbest_ok[it.p] = 1;
				end
				if (!round_ok || longint'(it.cost) < round_cost_m ||
					(longint'(it.cost) == round_cost_m && int'(it.p) <= round_idx)) begin
					for (int i = 0; i < psue_pkg::NUM_DIMS; i++)
						round_pos_m[i] = pos_m[base + i];
					round_cost_m = it.cost;
					round_idx = it.p;
					round_ok = 1;
				end
			end
			default: begin
				// first move of an iteration commits the round best
				if (!moving) begin
					if (round_ok && round_cost_m < swarm_cost_m) begin
						swarm_pos_m = round_pos_m;
						swarm_cost_m = round_cost_m;
					end
					moving = 1;
				end
				if (!pbest_ok[it.p]) begin
					for (int i = 0; i < psue_pkg::NUM_DIMS; i++)
						pbest_m[base + i] = pos_m[base + i];
					pbest_ok[it.p] = 1;
				end
				k1 = (gain_own * longint'(it.r1)) >>> 16;
				k2 = (gain_swarm * longint'(it.r2)) >>> 16;
				for (int i = 0; i < psue_pkg::NUM_DIMS; i++) begin
					x = pos_m[base + i];
					lo = low_m[i];
					hi = high_m[i];
					bst = follow_global ? swarm_pos_m[i] : round_pos_m[i];
					s = gain_m * vel_m[base + i] + k1 * (pbest_m[base + i] - x) + k2 * (bst - x);
					v = (s + 8192) >>> 14;
					vmax = (frac_m * (hi - lo)) >>> 16;
					if (v > vmax) v = vmax;
					if (v < -vmax) v = -vmax;
					if (v > 64'sd2147483647) v = 64'sd2147483647;
					if (v < -64'sd2147483648) v = -64'sd2147483648;
					nx = x + v;
					if (nx > hi) nx = hi;
					if (nx < lo) nx = lo;
					vel_m[base + i] = v;
					pos_m[base + i] = nx;
					if (i < psue_pkg::EMIT_N) begin
						u.p = it.p;
						u.d = psue_pkg::D_W'(i);
						u.pos = 32'(nx);
						u.vel = 32'(v);
						u.last = (i + 1 == psue_pkg::EMIT_N);
						pending_updates.push_back(u);
					end
				end
			end
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_updates.size() == 0) begin
				report_mismatch("unexpected result, particle", out_particle, -1);
			end else begin
				coord_update_t w;
				w = pending_updates.pop_front();
				if (out_particle !== w.p) report_mismatch("out_particle", out_particle, w.p);
				if (out_dim !== w.d) report_mismatch("out_dim", out_dim, w.d);
				if (out_position !== w.pos) report_mismatch("out_position", out_position, w.pos);
				if (out_velocity !== w.vel) report_mismatch("out_velocity", out_velocity, w.vel);
				if (last_dim !== w.last) report_mismatch("last_dim", last_dim, w.last);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 10);
	end

	task automatic send_request(input swarm_req_t it);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 10) begin
				in_valid = 1'b0;
				@(negedge clk);
			end
		end
		req_type = it.kind;
		particle_index = it.p;
		dim_index = it.d;
		value_a = it.a;
		value_b = it.b;
		cost_value = it.cost;
		rand_own = it.r1;
		rand_swarm = it.r2;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_request(it);
		@(negedge clk);
	endtask

	function automatic swarm_req_t make_req(psue_pkg::req_t k, int p, int d, longint a,
		longint b, longint c, int r1, int r2);
		swarm_req_t it;
		it.kind = k;
		it.p = psue_pkg::P_W'(p);
		it.d = psue_pkg::D_W'(d);
		it.a = 32'(a);
		it.b = 32'(b);
		it.cost = 32'(c);
		it.r1 = 16'(r1);
		it.r2 = 16'(r2);
		return it;
	endfunction

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_updates.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(input logic [psue_pkg::CFG_W-1:0] idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			psue_pkg::CFG_MOMENTUM:   gain_m = val;
			psue_pkg::CFG_OWN_GAIN:   gain_own = val;
			psue_pkg::CFG_SWARM_GAIN: gain_swarm = val;
			psue_pkg::CFG_SPEED_FRAC: frac_m = val;
			psue_pkg::CFG_USE_GLOBAL: follow_global = val[0];
			default: ;
		endcase
	endtask

	task automatic set_gains(input int m, input int c1, input int c2, input int f, input bit g);
		wait_idle();
		write_reg(psue_pkg::CFG_MOMENTUM, 16'(m));
		write_reg(psue_pkg::CFG_OWN_GAIN, 16'(c1));
		write_reg(psue_pkg::CFG_SWARM_GAIN, 16'(c2));
		write_reg(psue_pkg::CFG_SPEED_FRAC, 16'(f));
		write_reg(psue_pkg::CFG_USE_GLOBAL, {15'd0, g});
	endtask

	function automatic longint pick_pos(int d);
		if (high_m[d] > low_m[d])
			return low_m[d] + longint'($urandom) % (high_m[d] - low_m[d] + 1);
		return low_m[d];
	endfunction

	// bounds of every dimension, every coordinate, then one report
	task automatic test_load_swarm();
		longint lo;
		for (int d = 0; d < psue_pkg::NUM_DIMS; d++) begin
			lo = -longint'($urandom_range(0, 1 << 22));
			send_request(make_req(psue_pkg::REQ_BOUNDS, 0, d, lo,
				lo + $urandom_range(1, 1 << 23), 0, 0, 0));
		end
		for (int p = 0; p < psue_pkg::NUM_PARTICLES; p++)
			for (int d = 0; d < psue_pkg::NUM_DIMS; d++)
				send_request(make_req(psue_pkg::REQ_COORD, p, d, pick_pos(d),
					longint'($signed($urandom_range(0, 1 << 16))) - (1 << 15), 0, 0, 0));
		send_request(make_req(psue_pkg::REQ_COST, 0, 0, 0, 0, 1000, 0, 0));
	endtask

	// extremes of fields, ties, inverted bounds, missing personal best
	task automatic test_boundary_values();
		// particle 5 never reported: personal best taken from its position
		send_request(make_req(psue_pkg::REQ_MOVE, 5, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
		send_request(make_req(psue_pkg::REQ_MOVE, 0, 7, -1, -1, -1, 0, 0));
		// round ties: equal cost, lower index wins; cost extremes
		send_request(make_req(psue_pkg::REQ_COST, 3, 0, 0, 0, 7, 0, 0));
		send_request(make_req(psue_pkg::REQ_COST, 2, 0, 0, 0, 7, 0, 0));
		send_request(make_req(psue_pkg::REQ_COST, 3, 0, 0, 0, 7, 0, 0));
		send_request(make_req(psue_pkg::REQ_COST, 4, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0));
		send_request(make_req(psue_pkg::REQ_COST, 6, 0, 0, 0, -64'sd2147483648, 0, 0));
		send_request(make_req(psue_pkg::REQ_MOVE, 2, 0, 0, 0, 0, 16'h8000, 16'h0001));
		// widest range with coordinates at the extremes
		send_request(make_req(psue_pkg::REQ_BOUNDS, 0, 7, -64'sd2147483648, 64'sd2147483647,
			0, 0, 0));
		send_request(make_req(psue_pkg::REQ_COORD, 1, 7, 64'sd2147483647, 64'sd2147483647,
			0, 0, 0));
		send_request(make_req(psue_pkg::REQ_COORD, 9, 7, -64'sd2147483648, -64'sd2147483648,
			0, 0, 0));
		send_request(make_req(psue_pkg::REQ_MOVE, 1, 0, 0, 0, 0, 16'hFFFF, 0));
		send_request(make_req(psue_pkg::REQ_MOVE, 9, 0, 0, 0, 0, 0, 16'hFFFF));
		// inverted bounds
		send_request(make_req(psue_pkg::REQ_BOUNDS, 0, 3, 5000, -5000, 0, 0, 0));
		send_request(make_req(psue_pkg::REQ_MOVE, 4, 0, 0, 0, 0, 16'h1234, 16'hABCD));
		send_request(make_req(psue_pkg::REQ_BOUNDS, 0, 3, -200000, 200000, 0, 0, 0));
		send_request(make_req(psue_pkg::REQ_COST, 15, 0, 0, 0, -5, 0, 0));
		send_request(make_req(psue_pkg::REQ_MOVE, 15, 0, 0, 0, 0, 16'h7FFF, 16'h8000));
	endtask

	// random requests of mixed kind, mostly shaped iterations
	task automatic random_iterations(input int count);
		int sent, nrep, nmov;
		longint lo;
		sent = 0;
		while (sent < count) begin
			nrep = $urandom_range(1, 5);
			for (int i = 0; i < nrep; i++) begin
				send_request(make_req(psue_pkg::REQ_COST,
					$urandom_range(0, psue_pkg::NUM_PARTICLES - 1), 0,
					$urandom, $urandom,
					($urandom_range(0, 3) == 0) ? longint'($signed($urandom))
						: longint'($urandom_range(0, 20)) - 10,
					$urandom, $urandom));
				sent++;
			end
			nmov = $urandom_range(1, 4);
			for (int i = 0; i < nmov; i++) begin
				send_request(make_req(psue_pkg::REQ_MOVE,
					$urandom_range(0, psue_pkg::NUM_PARTICLES - 1),
					$urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, $urandom));
				sent++;
			end
			// noise: reloads of bounds and coordinates
			if ($urandom_range(0, 2) == 0) begin
				int d;
				d = $urandom_range(0, psue_pkg::NUM_DIMS - 1);
				if ($urandom_range(0, 1)) begin
					lo = longint'($signed($urandom)) >>> $urandom_range(0, 12);
					send_request(make_req(psue_pkg::REQ_BOUNDS, 0, d, lo,
						($urandom_range(0, 9) == 0) ? longint'($signed($urandom))
							: lo + $urandom_range(0, 1 << 24), 0, 0, 0));
				end else begin
					send_request(make_req(psue_pkg::REQ_COORD,
						$urandom_range(0, psue_pkg::NUM_PARTICLES - 1), d,
						($urandom_range(0, 4) == 0) ? longint'($signed($urandom)) : pick_pos(d),
						longint'($signed($urandom)) >>> $urandom_range(0, 16), 0, 0, 0));
				end
				sent++;
			end
		end
	endtask

	task automatic test_config_extremes();
		set_gains(0, 0, 0, 0, 1'b1);
		random_iterations(8);
		set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		random_iterations(10);
	endtask

	task automatic test_random_traffic();
		set_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535), 1'b1);
		random_iterations(20);
		quiet = 1;
		random_iterations(20);
		quiet = 0;
		set_gains($urandom_range(8000, 20000), $urandom_range(0, 40000),
			$urandom_range(0, 40000), $urandom_range(1000, 40000), 1'b0);
		random_iterations(15);
		set_gains(psue_pkg::RST_MOMENTUM, psue_pkg::RST_OWN_GAIN, psue_pkg::RST_SWARM_GAIN,
			psue_pkg::RST_SPEED_FRAC, 1'b1);
		random_iterations(15);
	endtask

	initial begin
		errors = 0;
		quiet = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = '0;
		particle_index = '0;
		dim_index = '0;
		value_a = '0;
		value_b = '0;
		cost_value = '0;
		rand_own = '0;
		rand_swarm = '0;
		out_stall = 1'b0;
		for (int i = 0; i < psue_pkg::NUM_PARTICLES * psue_pkg::NUM_DIMS; i++) begin
			pos_m[i] = 0; vel_m[i] = 0; pbest_m[i] = 0;
		end
		for (int p = 0; p < psue_pkg::NUM_PARTICLES; p++) begin
			pbest_cost_m[p] = psue_pkg::COST_MAX; pbest_ok[p] = 0;
		end
		for (int d = 0; d < psue_pkg::NUM_DIMS; d++) begin
			low_m[d] = 0; high_m[d] = 0; swarm_pos_m[d] = 0; round_pos_m[d] = 0;
		end
		swarm_cost_m = psue_pkg::COST_MAX;
		round_cost_m = psue_pkg::COST_MAX;
		round_ok = 0;
		round_idx = 0;
		moving = 0;
		gain_m = psue_pkg::RST_MOMENTUM;
		gain_own = psue_pkg::RST_OWN_GAIN;
		gain_swarm = psue_pkg::RST_SWARM_GAIN;
		frac_m = psue_pkg::RST_SPEED_FRAC;
		follow_global = 1;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_load_swarm();
		test_boundary_values();
		test_config_extremes();
		test_random_traffic();

		wait_idle();
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/psue_pkg.sv
rtl/psue_ram.sv
rtl/psue_ctrl.sv
rtl/psue_dp.sv
rtl/particle_swarm_update_engine.sv
sim/particle_swarm_update_engine_tb.sv
